// ----- src/sfd_pkg.sv -----
// Shared constants, types and saturation helper for the stereo feedback delay.
package sfd_pkg;

  localparam int STORE_DEPTH = 131072;
  localparam int SAMPLE_W    = 24;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int DLY_W       = 17;
  localparam int FRAC_W      = 16;
  localparam int GAIN_W      = FRAC_W + 1;
  localparam int UNITY       = 1 << FRAC_W;
  localparam int ACC_W       = SAMPLE_W + GAIN_W + 2;
  localparam int CMP_W       = ((ADDR_W > DLY_W) ? ADDR_W : DLY_W) + 1;
  localparam int REG_NUM     = 3;
  localparam int IDX_W       = $clog2(REG_NUM);
  localparam int APB_AW      = IDX_W + 2;
  localparam int APB_DW      = 32;

  typedef enum logic [IDX_W-1:0] {
    REG_DELAY    = 0,
    REG_FEEDBACK = 1,
    REG_WET      = 2
  } reg_idx_t;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [GAIN_W-1:0]          gain_t;
  typedef logic [ADDR_W-1:0]          addr_t;
  typedef logic signed [ACC_W-1:0]    acc_t;

  typedef struct packed {
    addr_t delay;
    gain_t fb;
    gain_t wet;
    gain_t dry;
  } cfg_t;

  typedef struct packed {
    logic  valid;
    addr_t wp;
    logic  hit;
    logic  filled;
  } ctl_t;

  localparam acc_t SAT_HI = {{(ACC_W-SAMPLE_W+1){1'b0}}, {(SAMPLE_W-1){1'b1}}};
  localparam acc_t SAT_LO = ~SAT_HI;

  function automatic sample_t sat(acc_t v);
    sample_t r;
    if (v > SAT_HI) begin
      r = SAT_HI[SAMPLE_W-1:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[SAMPLE_W-1:0];
    end else begin
      r = v[SAMPLE_W-1:0];
    end
    return r;
  endfunction

endpackage

// ----- src/sfd_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module sfd_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 131072
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- src/sfd_regs.sv -----
// APB register file holding delay, feedback gain and wet mix, with clamped views.
module sfd_regs
  import sfd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic [DLY_W-1:0]  delay_r;
  gain_t             fb_r;
  gain_t             wet_r;
  reg_idx_t          idx;
  logic              wr;
  logic [CMP_W-1:0]  d_wide;
  gain_t             wet_c;

  assign idx    = reg_idx_t'(paddr[APB_AW-1:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_r <= '0;
      fb_r    <= '0;
      wet_r   <= '0;
    end else if (wr) begin
      case (idx)
        REG_DELAY:    delay_r <= pwdata[DLY_W-1:0];
        REG_FEEDBACK: fb_r    <= pwdata[GAIN_W-1:0];
        REG_WET:      wet_r   <= pwdata[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_DELAY:    prdata = APB_DW'(delay_r);
      REG_FEEDBACK: prdata = APB_DW'(fb_r);
      REG_WET:      prdata = APB_DW'(wet_r);
      default:      prdata = '0;
    endcase
  end

  // Gains above unity saturate to unity; the delay saturates to the store depth minus one.
  assign d_wide = CMP_W'(delay_r);
  assign wet_c  = wet_r[GAIN_W-1] ? GAIN_W'(UNITY) : wet_r;

  always_comb begin
    if (d_wide > CMP_W'(STORE_DEPTH - 1)) begin
      cfg.delay = ADDR_W'(STORE_DEPTH - 1);
    end else begin
      cfg.delay = ADDR_W'(delay_r);
    end
    cfg.fb  = fb_r[GAIN_W-1] ? GAIN_W'(UNITY) : fb_r;
    cfg.wet = wet_c;
    cfg.dry = GAIN_W'(UNITY) - wet_c;
  end

endmodule

// ----- src/sfd_lane.sv -----
// One channel lane: delay store, feedback write-back with forwarding, and dry/wet mix.
module sfd_lane
  import sfd_pkg::*;
(
  input  logic    clk,
  input  logic    en,
  input  addr_t   rd_addr,
  input  sample_t x_in,
  input  ctl_t    ctl_s1,
  input  cfg_t    cfg,
  output sample_t y
);

  sample_t                 ram_q;
  sample_t                 x_s1_r;
  sample_t                 x_s2_r;
  sample_t                 dl_s2_r;
  sample_t                 w_fwd_r;
  sample_t                 dl;
  sample_t                 w;
  logic signed [ACC_W-2:0] p_fb;
  logic signed [ACC_W-2:0] pd_s3_r;
  logic signed [ACC_W-2:0] pw_s3_r;
  acc_t                    fb_sum;
  acc_t                    mix_sum;
  logic                    we;

  assign we = en && ctl_s1.valid;

  sfd_ram #(
    .WIDTH(SAMPLE_W),
    .DEPTH(STORE_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(ctl_s1.wp),
    .wdata(w),
    .re   (en),
    .raddr(rd_addr),
    .rdata(ram_q)
  );

  // The write made at the edge of this item's read is taken from the bypass register.
  always_comb begin
    if (ctl_s1.hit) begin
      dl = w_fwd_r;
    end else if (ctl_s1.filled) begin
      dl = ram_q;
    end else begin
      dl = '0;
    end
    p_fb   = dl * $signed({1'b0, cfg.fb});
    fb_sum = ACC_W'(x_s1_r) + (ACC_W'(p_fb) >>> FRAC_W);
    w      = sat(fb_sum);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_s1_r  <= x_in;
      x_s2_r  <= x_s1_r;
      dl_s2_r <= dl;
      pd_s3_r <= x_s2_r * $signed({1'b0, cfg.dry});
      pw_s3_r <= dl_s2_r * $signed({1'b0, cfg.wet});
    end
    if (we) begin
      w_fwd_r <= w;
    end
  end

  assign mix_sum = ACC_W'(pd_s3_r) + ACC_W'(pw_s3_r);
  assign y       = sat(mix_sum >>> FRAC_W);

endmodule

// ----- src/sfd_merge.sv -----
// Output register that joins both lanes and drives the pipeline advance.
module sfd_merge
  import sfd_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    s3_valid,
  input  sample_t y_l,
  input  sample_t y_r,
  input  logic    out_stall,
  output logic    out_valid,
  output sample_t left_out,
  output sample_t right_out,
  output logic    en
);

  logic    out_valid_r;
  sample_t left_r;
  sample_t right_r;

  assign en = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= s3_valid;
    end
    if (en) begin
      left_r  <= y_l;
      right_r <= y_r;
    end
  end

  assign out_valid = out_valid_r;
  assign left_out  = left_r;
  assign right_out = right_r;

endmodule

// ----- src/stereo_feedback_delay_unit.sv -----
// Top level of the stereo feedback delay: pointer control, two lanes and output merge.
//
//   Port group   Direction  Handshake           Payload
//   in_          input      in_valid/in_stall   in_left, in_right (signed 24 bits)
//   out_         output     out_valid/out_stall out_left, out_right (signed 24 bits)
//   APB          input      psel/penable/pready delay, feedback gain, wet mix
//
// One pair is taken each cycle unless stalled; it moves through s1, s2, s3 and the output.
// The rate is set by the feedback multiply-add loop in each lane, one pass per cycle.
// A stalled valid output freezes the whole pipeline and the input stalls in the same cycle.
// After reset the stores read as zero through fill tracking, so no clearing pass runs.
module stereo_feedback_delay_unit
  import sfd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  sample_t           in_left,
  input  sample_t           in_right,
  output logic              out_valid,
  input  logic              out_stall,
  output sample_t           out_left,
  output sample_t           out_right,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  cfg_t    cfg;
  logic    en;
  logic    acc;
  addr_t   wp_r;
  addr_t   wp_nxt;
  logic    wrapped_r;
  logic    wrapped_nxt;
  addr_t   rp;
  ctl_t    s1_r;
  ctl_t    s1_nxt;
  logic    s2_valid_r;
  logic    s3_valid_r;
  sample_t y_l;
  sample_t y_r;

  sfd_regs u_regs (
    .clk    (clk),
    .rst_n  (rst_n),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg    (cfg)
  );

  assign in_stall = !en;
  assign acc      = in_valid && en;

  always_comb begin
    if (wp_r >= cfg.delay) begin
      rp = wp_r - cfg.delay;
    end else begin
      rp = ADDR_W'(CMP_W'(wp_r) + CMP_W'(STORE_DEPTH) - CMP_W'(cfg.delay));
    end
    wp_nxt      = wp_r;
    wrapped_nxt = wrapped_r;
    if (acc) begin
      if (wp_r == ADDR_W'(STORE_DEPTH - 1)) begin
        wp_nxt      = '0;
        wrapped_nxt = 1'b1;
      end else begin
        wp_nxt = wp_r + 1'b1;
      end
    end
    s1_nxt.valid  = in_valid;
    s1_nxt.wp     = wp_r;
    s1_nxt.hit    = s1_r.valid && (s1_r.wp == rp);
    s1_nxt.filled = wrapped_r || (rp < wp_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r       <= '0;
      wrapped_r  <= 1'b0;
      s1_r       <= '0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else begin
      wp_r      <= wp_nxt;
      wrapped_r <= wrapped_nxt;
      if (en) begin
        s1_r       <= s1_nxt;
        s2_valid_r <= s1_r.valid;
        s3_valid_r <= s2_valid_r;
      end
    end
  end

  sfd_lane u_lane_l (
    .clk    (clk),
    .en     (en),
    .rd_addr(rp),
    .x_in   (in_left),
    .ctl_s1 (s1_r),
    .cfg    (cfg),
    .y      (y_l)
  );

  sfd_lane u_lane_r (
    .clk    (clk),
    .en     (en),
    .rd_addr(rp),
    .x_in   (in_right),
    .ctl_s1 (s1_r),
    .cfg    (cfg),
    .y      (y_r)
  );

  sfd_merge u_merge (
    .clk      (clk),
    .rst_n    (rst_n),
    .s3_valid (s3_valid_r),
    .y_l      (y_l),
    .y_r      (y_r),
    .out_stall(out_stall),
    .out_valid(out_valid),
    .left_out (out_left),
    .right_out(out_right),
    .en       (en)
  );

endmodule

// ----- src/sfd_checker.sv -----
// Port-level checks for the stereo feedback delay, bound to the top level.
module sfd_checker
  import sfd_pkg::*;
(
  input logic    clk,
  input logic    rst_n,
  input logic    in_valid,
  input logic    in_stall,
  input logic    out_valid,
  input logic    out_stall,
  input sample_t out_left,
  input sample_t out_right
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_left) && $stable(out_right))
    else $error("stalled result changed or was dropped");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while the output was free");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) ##1 !out_stall ##1 !out_stall ##1 !out_stall |=> out_valid)
    else $error("result of a transfer did not arrive after four free cycles");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result shown right after reset");

endmodule

bind stereo_feedback_delay_unit sfd_checker u_sfd_checker (.*);
